>>> sv/nlsp_pkg.sv
// shared constants, types and helper functions of the normalized legendre predictor
package nlsp_pkg;

   localparam int ORD_W       = 4;
   localparam int NSP_W       = 13;
   localparam int POS_W       = 12;
   localparam int VAL_W       = 32;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_IDX_W   = 1;

   localparam int DVS_W       = 13;
   localparam int DIV_STEP    = 4;
   localparam int CLAMP_W     = 36;

   localparam int SQRT_FRAC   = 28;
   localparam int SQRT_M_W    = 6;
   localparam int SQRT_STEPS  = 31;
   localparam int SQRT_RAD_W  = 2 * SQRT_STEPS;
   localparam int ROOT_W      = 31;

   localparam int SAT_W       = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_POLY_ORDER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SCAN   = 1'b1;

   localparam logic [ORD_W-1:0] POLY_ORDER_RST = 4'd1;
   localparam logic [NSP_W-1:0] NUM_SCAN_RST   = 13'd30;

   typedef struct packed {
      logic             start_x;
      logic             x_fin;
      logic             mul_xc;
      logic             t_rnd;
      logic             num_calc;
      logic             start_r;
      logic             r_fin;
      logic             mul_cs;
      logic             out_load;
      logic [ORD_W-1:0] k;
      logic [ORD_W-1:0] order;
   } nlsp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
   } nlsp_status_type;

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-VAL_W:0] top;
      top = v[SAT_W-1:VAL_W-1];
      if (top == '0 || top == '1) begin
         sat32 = v[VAL_W-1:0];
      end else if (v[SAT_W-1]) begin
         sat32 = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat32 = {1'b0, {(VAL_W-1){1'b1}}};
      end
   endfunction

endpackage

>>> sv/nlsp_div.sv
// iterative restoring divider, four quotient bits per cycle
module nlsp_div
   import nlsp_pkg::*;
#(
   parameter int DIV_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DIV_W-1:0] quotient
);

   localparam int ITERS = DIV_W / DIV_STEP;
   localparam int CNT_W = $clog2(ITERS + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   always_comb begin
      logic [DVS_W:0] trial;
      trial   = '0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(ITERS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_STEP; i++) begin
            trial  = {rem_in, quo_in[DIV_W-1]};
            quo_in = {quo_in[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in    = DVS_W'(trial - {1'b0, dvs_ff});
               quo_in[0] = 1'b1;
            end else begin
               rem_in = trial[DVS_W-1:0];
            end
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/nlsp_sqrt.sv
// bit-pair integer square root of (2n+1) scaled by 2^56
module nlsp_sqrt
   import nlsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SQRT_M_W-1:0] radicand_m,
   output logic                busy,
   output logic [ROOT_W-1:0]   root
);

   localparam int CNT_W = $clog2(SQRT_STEPS + 1);
   localparam int REM_W = ROOT_W + 2;

   logic [SQRT_RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   always_comb begin
      logic [REM_W+1:0] shifted;
      logic [REM_W-1:0] trial;
      shifted = {rem_ff, rad_ff[SQRT_RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = {radicand_m, {(SQRT_RAD_W-SQRT_M_W){1'b0}}};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(SQRT_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQRT_RAD_W-3:0], 2'b00};
         if (shifted >= {2'b00, trial}) begin
            rem_in  = REM_W'(shifted - {2'b00, trial});
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

>>> sv/nlsp_datapath.sv
// datapath: position scaling, shared multiplier, recurrence terms, divider and square root
module nlsp_datapath
   import nlsp_pkg::*;
#(
   parameter int FRAC_BITS = 26
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nlsp_cmd_type            cmd,
   input  logic [POS_W-1:0]        scan_pos,
   input  logic [NSP_W-1:0]        num_scan_positions,
   output nlsp_status_type         status,
   output logic signed [VAL_W-1:0] predictor_value
);

   localparam int T_W     = PROD_W - FRAC_BITS;
   localparam int NUM_W   = T_W + 6;
   localparam int XDIV_W  = FRAC_BITS + 14;
   localparam int DIV_RAW = (XDIV_W > CLAMP_W) ? XDIV_W : CLAMP_W;
   localparam int DIV_W   = ((DIV_RAW + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int QS_W    = DIV_W + 2;

   localparam logic signed [VAL_W-1:0]  ONE    = VAL_W'(PROD_W'(1) << FRAC_BITS);
   localparam logic signed [PROD_W-1:0] HALF_F = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] HALF_S = PROD_W'(1) << (SQRT_FRAC - 1);

   logic signed [VAL_W-1:0]  x_ff, x_in;
   logic signed [VAL_W-1:0]  prev_ff, prev_in;
   logic signed [VAL_W-1:0]  cur_ff, cur_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [T_W-1:0]    t_ff, t_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic                     dsgn_ff, dsgn_in;
   logic signed [VAL_W-1:0]  out_ff, out_in;

   logic [NSP_W-1:0]         nsp_c;
   logic [DVS_W-1:0]         dx;
   logic [POS_W-1:0]         pm1;
   logic [DIV_W-1:0]         x_div;
   logic [DVS_W-1:0]         dk;
   logic signed [NUM_W:0]    numx, hkx, rmag;
   logic [DIV_W-1:0]         r_div;
   logic                     div_start, div_busy;
   logic [DIV_W-1:0]         div_dividend, quotient;
   logic [DVS_W-1:0]         div_divisor;
   logic                     sqrt_busy;
   logic [ROOT_W-1:0]        root;
   logic signed [QS_W-1:0]   qs, qv, xv;
   logic signed [VAL_W-1:0]  x_new, r_new, mul_b;
   logic signed [PROD_W-1:0] mul_p, t_bias, t_sum, f_bias, f_sum;
   logic signed [5:0]        coef_a;
   logic signed [4:0]        coef_b;
   logic signed [NUM_W-1:0]  term_a, term_b;

   // position scaling dividend, rounding half folded in
   assign nsp_c = (num_scan_positions < NSP_W'(2)) ? NSP_W'(2) : num_scan_positions;
   assign dx    = DVS_W'(nsp_c - NSP_W'(1));
   assign pm1   = (scan_pos == '0) ? POS_W'(1) : scan_pos - POS_W'(1);
   assign x_div = (DIV_W'(pm1) << (FRAC_BITS + 1)) + DIV_W'(dx >> 1);

   // recurrence dividend: magnitude plus half divisor, clamped where it saturates anyway
   assign dk   = DVS_W'(cmd.k) + DVS_W'(1);
   assign numx = (NUM_W+1)'(num_ff);
   assign hkx  = signed'((NUM_W+1)'(dk >> 1));
   assign rmag = num_ff[NUM_W-1] ? (hkx - numx) : (numx + hkx);
   assign r_div = (|rmag[NUM_W:CLAMP_W]) ? DIV_W'({CLAMP_W{1'b1}})
                                         : DIV_W'(rmag[CLAMP_W-1:0]);

   assign div_start    = cmd.start_x | cmd.start_r;
   assign div_dividend = cmd.start_x ? x_div : r_div;
   assign div_divisor  = cmd.start_x ? dx : dk;

   nlsp_div #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   nlsp_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.start_x),
      .radicand_m ({1'b0, cmd.order, 1'b1}),
      .busy       (sqrt_busy),
      .root       (root)
   );

   assign status.div_busy  = div_busy;
   assign status.sqrt_busy = sqrt_busy;

   // signed quotient
   assign qs    = signed'(QS_W'(quotient));
   assign qv    = dsgn_ff ? -qs : qs;
   assign xv    = qv - QS_W'(ONE);
   assign x_new = sat32(SAT_W'(xv));
   assign r_new = sat32(SAT_W'(qv));

   // shared multiplier
   assign mul_b = cmd.mul_cs ? signed'({1'b0, root}) : x_ff;
   assign mul_p = cur_ff * mul_b;

   // round to nearest, ties away from zero
   assign t_bias = prod_ff[PROD_W-1] ? HALF_F - PROD_W'(1) : HALF_F;
   assign t_sum  = prod_ff + t_bias;
   assign f_bias = prod_ff[PROD_W-1] ? HALF_S - PROD_W'(1) : HALF_S;
   assign f_sum  = prod_ff + f_bias;

   assign coef_a = signed'({1'b0, cmd.k, 1'b1});
   assign coef_b = signed'({1'b0, cmd.k});
   assign term_a = t_ff * coef_a;
   assign term_b = prev_ff * coef_b;

   always_comb begin
      x_in    = x_ff;
      prev_in = prev_ff;
      cur_in  = cur_ff;
      prod_in = prod_ff;
      t_in    = t_ff;
      num_in  = num_ff;
      dsgn_in = dsgn_ff;
      out_in  = out_ff;
      if (cmd.start_x) begin
         dsgn_in = (scan_pos == '0);
      end
      if (cmd.start_r) begin
         dsgn_in = num_ff[NUM_W-1];
      end
      if (cmd.x_fin) begin
         x_in    = x_new;
         cur_in  = x_new;
         prev_in = ONE;
      end
      if (cmd.r_fin) begin
         prev_in = cur_ff;
         cur_in  = r_new;
      end
      if (cmd.mul_xc || cmd.mul_cs) begin
         prod_in = mul_p;
      end
      if (cmd.t_rnd) begin
         t_in = T_W'(t_sum >>> FRAC_BITS);
      end
      if (cmd.num_calc) begin
         num_in = term_a - term_b;
      end
      if (cmd.out_load) begin
         out_in = sat32(SAT_W'(f_sum >>> SQRT_FRAC));
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      t_ff    <= t_in;
      num_ff  <= num_in;
      dsgn_ff <= dsgn_in;
      out_ff  <= out_in;
   end

   assign predictor_value = out_ff;

endmodule

>>> sv/nlsp_ctrl.sv
// controller: sequences scaling, recurrence steps, final scaling and the result register
module nlsp_ctrl
   import nlsp_pkg::*;
#(
   parameter int MAX_ORDER = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [ORD_W-1:0] poly_order,
   input  nlsp_status_type  status,
   output nlsp_cmd_type     cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_XDIV  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_TRND  = 4'd3;
   localparam logic [3:0] S_NUM   = 4'd4;
   localparam logic [3:0] S_RLOAD = 4'd5;
   localparam logic [3:0] S_RDIV  = 4'd6;
   localparam logic [3:0] S_FWAIT = 4'd7;
   localparam logic [3:0] S_FOUT  = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [ORD_W-1:0] k_ff, k_in;
   logic [ORD_W-1:0] n_ff, n_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ORD_W-1:0] ord_c;

   always_comb begin
      ord_c = (poly_order == '0) ? ORD_W'(1) : poly_order;
      if ({1'b0, ord_c} > (ORD_W+1)'(MAX_ORDER)) begin
         ord_c = ORD_W'(MAX_ORDER);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.k        = k_ff;
      cmd.order    = ord_c;
      state_in     = state_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start_x = 1'b1;
               n_in        = ord_c;
               state_in    = S_XDIV;
            end
         end
         S_XDIV: begin
            if (!status.div_busy) begin
               cmd.x_fin = 1'b1;
               k_in      = ORD_W'(1);
               state_in  = (n_ff == ORD_W'(1)) ? S_FWAIT : S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_xc = 1'b1;
            state_in   = S_TRND;
         end
         S_TRND: begin
            cmd.t_rnd = 1'b1;
            state_in  = S_NUM;
         end
         S_NUM: begin
            cmd.num_calc = 1'b1;
            state_in     = S_RLOAD;
         end
         S_RLOAD: begin
            cmd.start_r = 1'b1;
            state_in    = S_RDIV;
         end
         S_RDIV: begin
            if (!status.div_busy) begin
               cmd.r_fin = 1'b1;
               k_in      = k_ff + ORD_W'(1);
               if (({1'b0, k_ff} + (ORD_W+1)'(1)) < {1'b0, n_ff}) begin
                  state_in = S_MUL;
               end else begin
                  state_in = S_FWAIT;
               end
            end
         end
         S_FWAIT: begin
            if (!status.sqrt_busy) begin
               cmd.mul_cs = 1'b1;
               state_in   = S_FOUT;
            end
         end
         S_FOUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         n_ff         <= ORD_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/normalized_legendre_scan_predictor.sv
// top level of the normalized legendre scan position predictor
//
//   channel   dir   handshake            payload
//   req       in    req_tvalid/tready    req_tdata[11:0] scan_pos
//   rsp       out   rsp_tvalid/tready    rsp_tdata[31:0] predictor_value
//   csr       in    csr_wr_en            csr_index, csr_wdata
//
// one item at a time; n = effective order. an item runs n - 1 recurrence steps, each
// one pass through the shared multiplier and the divider, which retires four
// quotient bits a cycle; the square root runs beside it, one bit a cycle.
// synchronous active-high reset; config registers return to order 1, 30 positions.
// a new item is taken while the previous result waits in the output register.
module normalized_legendre_scan_predictor
   import nlsp_pkg::*;
#(
   parameter int MAX_ORDER = 15,
   parameter int FRAC_BITS = 26
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [11:0] scan_pos
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] predictor_value
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [ORD_W-1:0]        poly_order_ff, poly_order_in;
   logic [NSP_W-1:0]        num_scan_ff, num_scan_in;
   nlsp_cmd_type            cmd;
   nlsp_status_type         status;
   logic signed [VAL_W-1:0] predictor_value;

   always_comb begin
      poly_order_in = poly_order_ff;
      num_scan_in   = num_scan_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_POLY_ORDER: poly_order_in = csr_wdata[ORD_W-1:0];
            CSR_NUM_SCAN:   num_scan_in   = csr_wdata[NSP_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_order_ff <= POLY_ORDER_RST;
         num_scan_ff   <= NUM_SCAN_RST;
      end else begin
         poly_order_ff <= poly_order_in;
         num_scan_ff   <= num_scan_in;
      end
   end

   nlsp_ctrl #(
      .MAX_ORDER (MAX_ORDER)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .poly_order (poly_order_ff),
      .status     (status),
      .cmd        (cmd)
   );

   nlsp_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .scan_pos           (req_tdata[POS_W-1:0]),
      .num_scan_positions (num_scan_ff),
      .status             (status),
      .predictor_value    (predictor_value)
   );

   assign rsp_tdata = predictor_value;

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in progress");

   assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_tready)
      else $error("divider busy while idle");

   assert property (@(posedge clock) disable iff (reset)
      status.sqrt_busy |-> !req_tready)
      else $error("square root busy while idle");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result loaded without returning to idle");

endmodule

>>> dv/predictor_value_checker.sv
// checker that predicts and compares the predictor_value results of the scan predictor
module predictor_value_checker
   import nlsp_pkg::*;
#(
   parameter int MAX_ORDER = 15,
   parameter int FRAC_BITS = 26
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [11:0] scan_pos
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] predictor_value
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ORD_W-1:0]        order_cfg;
   logic [NSP_W-1:0]        positions_cfg;
   logic signed [VAL_W-1:0] expected_values[$];

   // nearest, ties away from zero
   function automatic longint round_div(input longint num, input longint den);
      longint unsigned mag;
      longint unsigned dv;
      longint unsigned q;
      mag = (num < 0) ? -num : num;
      dv  = den;
      q   = (mag + dv / 2) / dv;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_word(input longint v);
      if (v > longint'(32'sh7fff_ffff)) return longint'(32'sh7fff_ffff);
      if (v < -(longint'(1) << 31)) return -(longint'(1) << 31);
      return v;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic logic signed [VAL_W-1:0] legendre_value(input logic [POS_W-1:0] pos,
                                                              input logic [ORD_W-1:0] ord,
                                                              input logic [NSP_W-1:0] span);
      longint          unity;
      longint          pp;
      longint          nn;
      longint          x;
      longint          prev;
      longint          cur;
      longint          t;
      longint          num;
      longint          nxt;
      longint          scale;
      longint unsigned radicand;
      int              n;
      unity = longint'(1) << FRAC_BITS;
      pp    = pos;
      nn    = span;
      n     = ord;
      if (n < 1) n = 1;
      if (n > MAX_ORDER) n = MAX_ORDER;
      if (nn < 2) nn = 2;
      x    = clamp_word(round_div((pp - 1) * 2 * unity, nn - 1) - unity);
      prev = unity;
      cur  = x;
      for (int k = 1; k < n; k++) begin
         t    = round_div(x * cur, unity);
         num  = (2 * k + 1) * t - k * prev;
         nxt  = clamp_word(round_div(num, k + 1));
         prev = cur;
         cur  = nxt;
      end
      radicand = 2 * n + 1;
      radicand = radicand << (2 * SQRT_FRAC);
      scale    = longint'(root_floor(radicand));
      return VAL_W'(clamp_word(round_div(cur * scale, longint'(1) << SQRT_FRAC)));
   endfunction

   always @(posedge clock) begin : watch
      logic signed [VAL_W-1:0] got;
      logic signed [VAL_W-1:0] want;
      if (reset) begin
         order_cfg     <= POLY_ORDER_RST;
         positions_cfg <= NUM_SCAN_RST;
         expected_values.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POLY_ORDER: order_cfg <= csr_wdata[ORD_W-1:0];
               CSR_NUM_SCAN:   positions_cfg <= csr_wdata[NSP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[VAL_W-1:0];
            if (expected_values.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               $display("%0t unexpected item: expected none, actual %0d", $time, got);
            end else begin
               want = expected_values.pop_front();
               if (got !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  $display("%0t predictor_value mismatch: expected %0d, actual %0d",
                           $time, want, got);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_values.push_back(legendre_value(req_tdata[POS_W-1:0], order_cfg,
                                                     positions_cfg));
      end
      outstanding <= expected_values.size();
   end

endmodule

>>> dv/tb_normalized_legendre_scan_predictor.sv
// testbench top: stimulus, csr settings and verdict for the scan position predictor
module tb_normalized_legendre_scan_predictor
   import nlsp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int SETTLE_CYCLES = 250;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_POLY_ORDER;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int cycle_count;
   int burst_left;
   bit steady;

   normalized_legendre_scan_predictor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   predictor_value_checker value_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial forever #10 clock = ~clock;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // receiver stalls in stretches of changing character
   initial begin
      int mode;
      int stretch;
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(1, 60);
         repeat (stretch) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= 1'b0;
            endcase
         end
      end
   end

   task automatic send(input logic [POS_W-1:0] pos);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(pos);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_paced(input logic [POS_W-1:0] pos);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!steady && $urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      send(pos);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_settings(input logic [ORD_W-1:0] ord, input logic [NSP_W-1:0] span);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_POLY_ORDER;
      csr_wdata <= {(CSR_DATA_W - ORD_W)'($urandom), ord};
      @(posedge clock);
      csr_index <= CSR_NUM_SCAN;
      csr_wdata <= span;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [POS_W-1:0] pick_position(input logic [NSP_W-1:0] span);
      int top;
      top = (span < 2) ? 2 : span;
      if (top > 4095) top = 4095;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return POS_W'(1);
               2: return POS_W'(top);
               3: return POS_W'((top < 4095) ? top + 1 : 4095);
               default: return '1;
            endcase
         end
         1, 2: return POS_W'($urandom_range(0, 4095));
         default: return POS_W'($urandom_range(1, top));
      endcase
   endfunction

   initial begin
      int n_sent;
      int phase_len;
      logic [ORD_W-1:0] ord;
      logic [NSP_W-1:0] span;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings out of reset
      send(1);
      send(15);
      send(30);
      send(0);
      drain();
      write_settings(15, 2);
      send(1);
      send(2);
      send(0);
      send(3);
      send(4095);
      // order zero and too few positions
      drain();
      write_settings(0, 0);
      send(1);
      send(2);
      send(0);
      drain();
      write_settings(15, 4096);
      send(1);
      send(2048);
      send(4095);
      drain();
      write_settings(7, 1);
      send(1);
      send(2);
      drain();
      write_settings(15, 8191);
      send(4095);
      send(1);

      n_sent = 0;
      while (n_sent < RANDOM_ITEMS) begin
         drain();
         case ($urandom_range(0, 5))
            0: ord = '0;
            1: ord = 4'd15;
            default: ord = ORD_W'($urandom_range(1, 15));
         endcase
         case ($urandom_range(0, 7))
            0: span = NSP_W'($urandom_range(0, 1));
            1: span = 13'd2;
            2: span = 13'd3;
            3: span = 13'd4096;
            4: span = 13'd8191;
            5: span = NSP_W'($urandom_range(0, 8191));
            default: span = NSP_W'($urandom_range(2, 4096));
         endcase
         write_settings(ord, span);
         steady     = ($urandom_range(0, 4) == 0);
         burst_left = 0;
         phase_len  = $urandom_range(20, 100);
         repeat (phase_len) begin
            send_paced(pick_position(span));
            n_sent++;
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/nlsp_pkg.sv
sv/nlsp_div.sv
sv/nlsp_sqrt.sv
sv/nlsp_datapath.sv
sv/nlsp_ctrl.sv
sv/normalized_legendre_scan_predictor.sv
dv/predictor_value_checker.sv
dv/tb_normalized_legendre_scan_predictor.sv
